[src/fpa_pkg.sv]
`timescale 1ns / 1ps
// Package for the fixed-point ALU: command codes, pipeline control types
// and the saturation helpers shared by the front end and the finish stage.
// No dependencies.
package fpa_pkg;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_MUL     = 4'd2,
        CMD_DIV     = 4'd3,
        CMD_MIN     = 4'd4,
        CMD_MAX     = 4'd5,
        CMD_INC     = 4'd6,
        CMD_DEC     = 4'd7,
        CMD_INT2FIX = 4'd8,
        CMD_FIX2INT = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op  op;
        logic neg;
        logic ovf;
        logic dz;
        logic less;
        logic equal;
        logic greater;
    } t_ctl;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
    } t_sat;

    typedef struct packed {
        logic [31:0] result;
        logic        less;
        logic        equal;
        logic        greater;
        logic        overflow;
        logic        divide_by_zero;
    } t_res;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_NEG = 32'h8000_0000;

    function automatic t_sat sat33(input logic [32:0] v);
        t_sat s;
        s.value = v[31:0];
        s.ovf   = 1'b0;
        if (v[32] != v[31]) begin
            s.ovf   = 1'b1;
            s.value = v[32] ? MIN_NEG : MAX_POS;
        end
        return s;
    endfunction

    function automatic t_sat from_mag(input logic [63:0] mag, input logic neg);
        t_sat s;
        s.ovf   = 1'b0;
        s.value = mag[31:0];
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                s.value = MIN_NEG;
                s.ovf   = 1'b1;
            end else begin
                s.value = (~mag[31:0]) + 32'd1;
            end
        end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
            s.value = MAX_POS;
            s.ovf   = 1'b1;
        end
        return s;
    endfunction

endpackage

[src/fpa_front.sv]
`timescale 1ns / 1ps
// Front end of the fixed-point ALU: decodes the command, computes the simple
// results and the magnitude product, and prepares the divider operands.
// Depends on fpa_pkg.
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic [3:0]                    i_command,
    input  logic signed [31:0]            i_operand_a,
    input  logic signed [31:0]            i_operand_b,
    output t_ctl                          o_ctl,
    output logic [63:0]                   o_word,
    output logic [32+FRACTION_BITS-1:0]   o_num
);

    t_cmd        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic        a_neg;
    logic        b_neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] addend;
    logic        cin;
    logic [32:0] sum;
    logic [63:0] wide;
    logic        i2f_fit;
    logic [32:0] rnd;
    logic [63:0] product;
    t_sat        sat_sum;
    t_sat        sat_f2i;

    assign cmd   = t_cmd'(i_command);
    assign a     = i_operand_a;
    assign b     = i_operand_b;
    assign a_neg = a[31];
    assign b_neg = b[31];
    assign mag_a = a_neg ? (~a) + 32'd1 : a;
    assign mag_b = b_neg ? (~b) + 32'd1 : b;

    always_comb begin
        addend = {b[31], b};
        cin    = 1'b0;
        case (cmd)
            CMD_SUB: begin
                addend = ~{b[31], b};
                cin    = 1'b1;
            end
            CMD_INC: addend = 33'd1;
            CMD_DEC: addend = '1;
            default: addend = {b[31], b};
        endcase
    end

    assign sum     = {a[31], a} + addend + {32'b0, cin};
    assign sat_sum = sat33(sum);
    assign wide    = {{32{a[31]}}, a} << FRACTION_BITS;
    assign i2f_fit = (&wide[63:31]) | ~(|wide[63:31]);
    assign rnd     = ({1'b0, mag_a} + (33'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    assign sat_f2i = from_mag({31'b0, rnd}, a_neg);
    assign product = {32'b0, mag_a} * {32'b0, mag_b};
    assign o_num   = {mag_a, {FRACTION_BITS{1'b0}}};

    always_comb begin
        o_ctl.op      = OP_PASS;
        o_ctl.neg     = a_neg ^ b_neg;
        o_ctl.ovf     = 1'b0;
        o_ctl.dz      = 1'b0;
        o_ctl.less    = i_operand_a < i_operand_b;
        o_ctl.equal   = i_operand_a == i_operand_b;
        o_ctl.greater = i_operand_a > i_operand_b;
        o_word        = '0;
        unique case (cmd) inside
            CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
                o_word    = {32'b0, sat_sum.value};
                o_ctl.ovf = sat_sum.ovf;
            end
            CMD_MUL: begin
                o_ctl.op = OP_MUL;
                o_word   = product;
            end
            CMD_DIV: begin
                if (b == 32'd0) begin
                    o_ctl.dz = 1'b1;
                    o_word   = {32'b0, a_neg ? MIN_NEG : MAX_POS};
                end else begin
                    o_ctl.op = OP_DIV;
                    o_word   = {32'b0, mag_b};
                end
            end
            CMD_MIN: o_word = {32'b0, o_ctl.greater ? b : a};
            CMD_MAX: o_word = {32'b0, o_ctl.less ? b : a};
            CMD_INT2FIX: begin
                if (i2f_fit) begin
                    o_word = {32'b0, wide[31:0]};
                end else begin
                    o_word    = {32'b0, a_neg ? MIN_NEG : MAX_POS};
                    o_ctl.ovf = 1'b1;
                end
            end
            CMD_FIX2INT: o_word = {32'b0, sat_f2i.value};
            default: o_word = '0;
        endcase
    end

endmodule

[src/fpa_div_cell.sv]
`timescale 1ns / 1ps
// One cell of the divider chain: a restoring division step that produces one
// quotient bit and carries the rest of the transaction to the next cell.
// Depends on fpa_pkg.
module fpa_div_cell
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  t_ctl                          i_ctl,
    input  logic [63:0]                   i_word,
    input  logic [31:0]                   i_rem,
    input  logic [32+FRACTION_BITS-1:0]   i_num,
    input  logic [32:0]                   i_quo,
    input  logic                          i_big,
    output logic                          o_valid,
    output t_ctl                          o_ctl,
    output logic [63:0]                   o_word,
    output logic [31:0]                   o_rem,
    output logic [32+FRACTION_BITS-1:0]   o_num,
    output logic [32:0]                   o_quo,
    output logic                          o_big
);

    localparam int NUM_W = 32 + FRACTION_BITS;

    logic                r_valid;
    t_ctl                r_ctl;
    logic [63:0]         r_word;
    logic [31:0]         r_rem;
    logic [NUM_W-1:0]    r_num;
    logic [32:0]         r_quo;
    logic                r_big;
    logic [32:0]         trial;
    logic [32:0]         diff;
    logic                ge;
    logic [31:0]         n_rem;

    assign trial = {i_rem, i_num[NUM_W-1]};
    assign diff  = trial - {1'b0, i_word[31:0]};
    assign ge    = trial >= {1'b0, i_word[31:0]};
    assign n_rem = ge ? diff[31:0] : trial[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctl  <= i_ctl;
            r_word <= i_word;
            r_rem  <= n_rem;
            r_num  <= {i_num[NUM_W-2:0], 1'b0};
            r_quo  <= {i_quo[31:0], ge};
            r_big  <= i_big | i_quo[32];
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_word  = r_word;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_big   = r_big;

endmodule

[src/fpa_finish.sv]
`timescale 1ns / 1ps
// Finish stage of the fixed-point ALU: rounds and saturates the product and
// the quotient, and assembles the result record with its flags.
// Depends on fpa_pkg.
module fpa_finish
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  t_ctl         i_ctl,
    input  logic [63:0]  i_word,
    input  logic [31:0]  i_rem,
    input  logic [32:0]  i_quo,
    input  logic         i_big,
    output t_res         o_res
);

    logic [63:0] mul_sum;
    logic [63:0] mul_mag;
    logic        rb;
    logic [33:0] q;
    logic [63:0] div_mag;
    t_sat        sat_mul;
    t_sat        sat_div;

    assign mul_sum = i_word + (64'd1 << (FRACTION_BITS - 1));
    assign mul_mag = mul_sum >> FRACTION_BITS;
    assign sat_mul = from_mag(mul_mag, i_ctl.neg);

    assign rb      = {i_rem, 1'b0} >= {1'b0, i_word[31:0]};
    assign q       = {1'b0, i_quo} + {33'b0, rb};
    assign div_mag = i_big ? '1 : {30'b0, q};
    assign sat_div = from_mag(div_mag, i_ctl.neg);

    always_comb begin
        o_res.less           = i_ctl.less;
        o_res.equal          = i_ctl.equal;
        o_res.greater        = i_ctl.greater;
        o_res.divide_by_zero = i_ctl.dz;
        case (i_ctl.op)
            OP_MUL: begin
                o_res.result   = sat_mul.value;
                o_res.overflow = sat_mul.ovf;
            end
            OP_DIV: begin
                o_res.result   = sat_div.value;
                o_res.overflow = sat_div.ovf;
            end
            default: begin
                o_res.result   = i_word[31:0];
                o_res.overflow = i_ctl.ovf;
            end
        endcase
    end

endmodule

[src/fixed_point_alu_core.sv]
`timescale 1ns / 1ps
// Top level of the signed 32-bit fixed-point ALU with FRACTION_BITS fraction bits.
// Depends on fpa_pkg, fpa_front, fpa_div_cell and fpa_finish.
//
// Usage: a transaction on the input channel (i_in_valid, o_in_ready) carries a
// command and two raw operands; each one produces exactly one transaction on
// the output channel (o_out_valid, i_out_ready), in order.
// Every transaction, whatever its command, passes through a front register, a
// chain of 32 + FRACTION_BITS divider cells (one quotient bit per cell) and an
// output register; with the default FRACTION_BITS of 8 the format is Q24.8.
// Throughput is one transaction per cycle while the skid register is empty; up
// to FRACTION_BITS + 35 transactions can be in flight.
// Reset empties the pipeline and the output register; no results are pending.
// When the receiver stalls, the output register holds its result and one more
// result is caught in a skid register; the whole chain then freezes and
// o_in_ready stays low until the receiver takes the held result.
module fixed_point_alu_core
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [3:0]          i_command,
    input  logic signed [31:0]  i_operand_a,
    input  logic signed [31:0]  i_operand_b,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_result,
    output logic                o_less,
    output logic                o_equal,
    output logic                o_greater,
    output logic                o_overflow,
    output logic                o_divide_by_zero
);

    localparam int NUM_W = 32 + FRACTION_BITS;

    logic                en;
    t_ctl                f_ctl;
    logic [63:0]         f_word;
    logic [NUM_W-1:0]    f_num;

    logic                r_s0_valid;
    t_ctl                r_s0_ctl;
    logic [63:0]         r_s0_word;
    logic [NUM_W-1:0]    r_s0_num;

    logic                s_valid [0:NUM_W];
    t_ctl                s_ctl   [0:NUM_W];
    logic [63:0]         s_word  [0:NUM_W];
    logic [31:0]         s_rem   [0:NUM_W];
    logic [NUM_W-1:0]    s_num   [0:NUM_W];
    logic [32:0]         s_quo   [0:NUM_W];
    logic                s_big   [0:NUM_W];

    t_res                fin_res;
    logic                fin_valid;
    logic                r_out_valid;
    t_res                r_out;
    logic                r_skid_valid;
    t_res                r_skid;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    fpa_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_command  (i_command),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .o_ctl      (f_ctl),
        .o_word     (f_word),
        .o_num      (f_num)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
        end
        if (en) begin
            r_s0_ctl  <= f_ctl;
            r_s0_word <= f_word;
            r_s0_num  <= f_num;
        end
    end

    assign s_valid[0] = r_s0_valid;
    assign s_ctl[0]   = r_s0_ctl;
    assign s_word[0]  = r_s0_word;
    assign s_rem[0]   = '0;
    assign s_num[0]   = r_s0_num;
    assign s_quo[0]   = '0;
    assign s_big[0]   = 1'b0;

    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        fpa_div_cell #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(s_valid[k]),
            .i_ctl  (s_ctl[k]),
            .i_word (s_word[k]),
            .i_rem  (s_rem[k]),
            .i_num  (s_num[k]),
            .i_quo  (s_quo[k]),
            .i_big  (s_big[k]),
            .o_valid(s_valid[k+1]),
            .o_ctl  (s_ctl[k+1]),
            .o_word (s_word[k+1]),
            .o_rem  (s_rem[k+1]),
            .o_num  (s_num[k+1]),
            .o_quo  (s_quo[k+1]),
            .o_big  (s_big[k+1])
        );
    end

    fpa_finish #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_finish (
        .i_ctl (s_ctl[NUM_W]),
        .i_word(s_word[NUM_W]),
        .i_rem (s_rem[NUM_W]),
        .i_quo (s_quo[NUM_W]),
        .i_big (s_big[NUM_W]),
        .o_res (fin_res)
    );

    assign fin_valid = s_valid[NUM_W] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (fin_valid) begin
                r_out       <= fin_res;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (fin_valid) begin
            r_skid       <= fin_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result         = r_out.result;
    assign o_less           = r_out.less;
    assign o_equal          = r_out.equal;
    assign o_greater        = r_out.greater;
    assign o_overflow       = r_out.overflow;
    assign o_divide_by_zero = r_out.divide_by_zero;

endmodule
